/* rtl/core/aatk_pkg.sv */
`timescale 1ns / 1ps
// aatk_pkg: segment table, field widths and shared types for adc_average_to_kelvin
// no dependencies; imported by every module of the block

package aatk_pkg;

   localparam int CHANNEL_BITS  = 3;
   localparam int KELVIN_BITS   = 9;
   localparam int SEGMENTS      = 9;
   localparam int SEG_IDX_BITS  = $clog2(SEGMENTS);
   localparam int SEG_BASE_BITS = 6;
   localparam int SEG_BP_BITS   = 10;
   localparam int SEG_D100_BITS = 11;

   typedef logic [CHANNEL_BITS-1:0]  channel_type;
   typedef logic [KELVIN_BITS-1:0]   kelvin_type;
   typedef logic [SEG_IDX_BITS-1:0]  seg_idx_type;
   typedef logic [SEG_BASE_BITS-1:0] seg_base_type;
   typedef logic [SEG_BP_BITS-1:0]   seg_bp_type;
   typedef logic [SEG_D100_BITS-1:0] seg_d100_type;

   localparam logic [KELVIN_BITS-1:0] KELVIN_OFFSET = 9'd273;
   localparam logic [KELVIN_BITS-1:0] KELVIN_MAX    = 9'd511;

   // celsius at the segment breakpoint
   localparam seg_base_type SEG_BASE [SEGMENTS] = '{
      6'd5, 6'd10, 6'd15, 6'd20, 6'd25, 6'd30, 6'd35, 6'd40, 6'd45
   };

   // upper code of each segment, also the code where the base applies
   localparam seg_bp_type SEG_BP [SEGMENTS] = '{
      10'd289, 10'd342, 10'd398, 10'd455, 10'd512, 10'd566, 10'd619, 10'd667, 10'd712
   };

   // codes per degree, in hundredths
   localparam seg_d100_type SEG_D100 [SEGMENTS] = '{
      11'd982, 11'd1060, 11'd1112, 11'd1136, 11'd1132, 11'd1100, 11'd1044, 11'd973, 11'd890
   };

   // signed width of code minus breakpoint, also enough for the celsius value
   function automatic int diff_bits(input int sample_bits);
      int w;
      w = (sample_bits > SEG_BP_BITS) ? sample_bits : SEG_BP_BITS;
      return w + 1;
   endfunction

endpackage

/* rtl/core/aatk_if.sv */
`timescale 1ns / 1ps
// aatk_req_if, aatk_rsp_if: sample and result channels with valid/ready
// depends on aatk_pkg for the field types

interface aatk_req_if
   import aatk_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   channel_type            channel;
   logic                   first;
   logic                   last;

   modport source (output valid, output sample, output channel, output first, output last,
                   input ready);
   modport sink   (input valid, input sample, input channel, input first, input last,
                   output ready);
endinterface

interface aatk_rsp_if
   import aatk_pkg::*;
();
   logic        valid;
   logic        ready;
   kelvin_type  kelvin;
   channel_type channel_out;

   modport source (output valid, output kelvin, output channel_out, input ready);
   modport sink   (input valid, input kelvin, input channel_out, output ready);
endinterface

/* rtl/core/aatk_average.sv */
`timescale 1ns / 1ps
// aatk_average: burst running average and the register that holds the code to convert
// depends on aatk_pkg and aatk_req_if

module aatk_average
   import aatk_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   aatk_req_if.sink               req_if,
   output logic                   code_valid,
   input  logic                   code_ready,
   output logic [SAMPLE_BITS-1:0] code,
   output channel_type            code_channel
);

   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [SAMPLE_BITS:0]   avg_sum;
   logic                   valid_ff, valid_in;
   logic [SAMPLE_BITS-1:0] code_ff;
   channel_type            ch_ff;
   logic                   stage_ready;
   logic                   accept;

   assign stage_ready  = !valid_ff || code_ready;
   assign req_if.ready = stage_ready;
   assign accept       = req_if.valid && stage_ready;

   always_comb begin
      avg_sum = {1'b0, avg_ff} + {1'b0, req_if.sample};
      avg_in  = req_if.first ? req_if.sample : avg_sum[SAMPLE_BITS:1];
   end

   always_comb begin
      valid_in = valid_ff;
      if (stage_ready) begin
         valid_in = accept && req_if.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            avg_ff <= avg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_if.last) begin
         code_ff <= avg_in;
         ch_ff   <= req_if.channel;
      end
   end

   assign code_valid   = valid_ff;
   assign code         = code_ff;
   assign code_channel = ch_ff;

   // first sample of a burst loads the average
   a_first_loads: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.first |=> avg_ff == $past(req_if.sample))
      else $error("average not loaded by first sample");

   // average only moves on a transfer
   a_avg_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(avg_ff))
      else $error("average changed without transfer");

   // averaging never leaves the interval of its two operands
   a_avg_bounded: assert property (@(posedge clock) disable iff (reset)
      accept && !req_if.first |=>
         (avg_ff >= $past(avg_ff) || avg_ff >= $past(req_if.sample)) &&
         (avg_ff <= $past(avg_ff) || avg_ff <= $past(req_if.sample)))
      else $error("average outside operand range");

endmodule

/* rtl/core/aatk_segment.sv */
`timescale 1ns / 1ps
// aatk_segment: segment select and slope multiply (code - breakpoint) * reciprocal
// depends on aatk_pkg for the segment table

module aatk_segment
   import aatk_pkg::*;
#(
   parameter int SAMPLE_BITS     = 10,
   parameter int RECIP_FRAC_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] code,
   input  channel_type            in_channel,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic signed [diff_bits(SAMPLE_BITS)+RECIP_FRAC_BITS-2:0] product,
   output seg_idx_type            out_seg,
   output channel_type            out_channel
);

   localparam int DIFF_BITS  = diff_bits(SAMPLE_BITS);
   // largest reciprocal is below 2^(frac - 3)
   localparam int RECIP_BITS = RECIP_FRAC_BITS - 2;
   localparam int PROD_BITS  = DIFF_BITS + RECIP_BITS + 1;
   localparam logic [63:0] ONE_HUNDRED = 64'd100 << RECIP_FRAC_BITS;

   localparam logic [RECIP_BITS-1:0] RECIP [SEGMENTS] = '{
      RECIP_BITS'((ONE_HUNDRED + 64'(SEG_D100[0] / 2)) / 64'(SEG_D100[0])),
      RECIP_BITS'((ONE_HUNDRED + 64'(SEG_D100[1] / 2)) / 64'(SEG_D100[1])),
      RECIP_BITS'((ONE_HUNDRED + 64'(SEG_D100[2] / 2)) / 64'(SEG_D100[2])),
      RECIP_BITS'((ONE_HUNDRED + 64'(SEG_D100[3] / 2)) / 64'(SEG_D100[3])),
      RECIP_BITS'((ONE_HUNDRED + 64'(SEG_D100[4] / 2)) / 64'(SEG_D100[4])),
      RECIP_BITS'((ONE_HUNDRED + 64'(SEG_D100[5] / 2)) / 64'(SEG_D100[5])),
      RECIP_BITS'((ONE_HUNDRED + 64'(SEG_D100[6] / 2)) / 64'(SEG_D100[6])),
      RECIP_BITS'((ONE_HUNDRED + 64'(SEG_D100[7] / 2)) / 64'(SEG_D100[7])),
      RECIP_BITS'((ONE_HUNDRED + 64'(SEG_D100[8] / 2)) / 64'(SEG_D100[8]))
   };

   logic                        valid_ff;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   seg_idx_type                 seg_ff, seg_in;
   channel_type                 ch_ff;
   logic [DIFF_BITS-1:0]        code_ext;
   logic signed [DIFF_BITS-1:0] diff;
   logic signed [RECIP_BITS:0]  recip_s;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      code_ext = {{(DIFF_BITS-SAMPLE_BITS){1'b0}}, code};
      seg_in   = seg_idx_type'(SEGMENTS - 1);
      for (int k = SEGMENTS - 2; k >= 0; k--) begin
         if (code_ext <= DIFF_BITS'(SEG_BP[k])) begin
            seg_in = seg_idx_type'(k);
         end
      end
      diff    = $signed(code_ext - DIFF_BITS'(SEG_BP[seg_in]));
      recip_s = $signed({1'b0, RECIP[seg_in]});
      prod_in = diff * recip_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
         seg_ff  <= seg_in;
         ch_ff   <= in_channel;
      end
   end

   assign out_valid   = valid_ff;
   assign product     = prod_ff;
   assign out_seg     = seg_ff;
   assign out_channel = ch_ff;

endmodule

/* rtl/core/aatk_kelvin.sv */
`timescale 1ns / 1ps
// aatk_kelvin: adds the segment base, truncates toward zero, offsets to kelvin, clamps
// depends on aatk_pkg and aatk_rsp_if; holds the result register

module aatk_kelvin
   import aatk_pkg::*;
#(
   parameter int SAMPLE_BITS     = 10,
   parameter int RECIP_FRAC_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic signed [diff_bits(SAMPLE_BITS)+RECIP_FRAC_BITS-2:0] product,
   input  seg_idx_type in_seg,
   input  channel_type in_channel,
   aatk_rsp_if.source  rsp_if
);

   localparam int DIFF_BITS = diff_bits(SAMPLE_BITS);
   localparam int PROD_BITS = DIFF_BITS + RECIP_FRAC_BITS - 1;
   localparam int SUM_BITS  = DIFF_BITS + RECIP_FRAC_BITS;
   localparam int KSUM_BITS = DIFF_BITS + 1;

   logic                       sum_valid_ff;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   channel_type                sum_ch_ff;
   logic                       sum_ready;

   logic                       out_valid_ff;
   kelvin_type                 kelvin_ff, kelvin_in;
   channel_type                out_ch_ff;
   logic                       out_ready;

   logic [SUM_BITS-1:0]        biased;
   logic [DIFF_BITS-1:0]       celsius;
   logic [KSUM_BITS-1:0]       kel_sum;

   assign out_ready = !out_valid_ff || rsp_if.ready;
   assign sum_ready = !sum_valid_ff || out_ready;
   assign in_ready  = sum_ready;

   always_comb begin
      sum_in = $signed({{(SUM_BITS-SEG_BASE_BITS-RECIP_FRAC_BITS){1'b0}}, SEG_BASE[in_seg],
                        {RECIP_FRAC_BITS{1'b0}}})
             + $signed({{(SUM_BITS-PROD_BITS){product[PROD_BITS-1]}}, product});
   end

   // truncate toward zero: negative sums get frac-all-ones before the shift
   always_comb begin
      biased  = sum_ff[SUM_BITS-1]
              ? sum_ff + {{(SUM_BITS-RECIP_FRAC_BITS){1'b0}}, {RECIP_FRAC_BITS{1'b1}}}
              : sum_ff;
      celsius = biased[SUM_BITS-1:RECIP_FRAC_BITS];
      kel_sum = {celsius[DIFF_BITS-1], celsius} + KSUM_BITS'(KELVIN_OFFSET);
      if (kel_sum[KSUM_BITS-1]) begin
         kelvin_in = '0;
      end else if (kel_sum > KSUM_BITS'(KELVIN_MAX)) begin
         kelvin_in = KELVIN_MAX;
      end else begin
         kelvin_in = kel_sum[KELVIN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (sum_ready) begin
            sum_valid_ff <= in_valid;
         end
         if (out_ready) begin
            out_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && sum_ready) begin
         sum_ff    <= sum_in;
         sum_ch_ff <= in_channel;
      end
      if (sum_valid_ff && out_ready) begin
         kelvin_ff <= kelvin_in;
         out_ch_ff <= sum_ch_ff;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.kelvin      = kelvin_ff;
   assign rsp_if.channel_out = out_ch_ff;

   // a negative celsius sum never lands above the offset
   a_neg_below_offset: assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff && out_ready && sum_ff[SUM_BITS-1] |=> kelvin_ff <= KELVIN_OFFSET)
      else $error("negative sum gave kelvin above offset");

   // a nonnegative sum never lands below the offset
   a_pos_above_offset: assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff && out_ready && !sum_ff[SUM_BITS-1] |=> kelvin_ff >= KELVIN_OFFSET)
      else $error("nonnegative sum gave kelvin below offset");

   // result register only fills from a valid sum stage
   a_out_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(sum_valid_ff))
      else $error("result valid without sum stage");

endmodule

/* rtl/core/adc_average_to_kelvin.sv */
`timescale 1ns / 1ps
// adc_average_to_kelvin: burst averaging of ADC samples and thermistor conversion to kelvin
// depends on aatk_pkg, aatk_if, aatk_average, aatk_segment, aatk_kelvin
//
//   port    dir  fields                                  transfer
//   req_if  in   sample, channel, first, last            valid && ready
//   rsp_if  out  kelvin, channel_out                     valid && ready
//
// one sample per cycle while no stall holds the pipeline; a sample with last set has its result
// passed in turn through the stages average, segment multiply, base add and truncate/clamp
// synchronous reset clears the running average and all stage valids
// a stalled result holds the pipeline; the four stage registers absorb up to four results

module adc_average_to_kelvin
   import aatk_pkg::*;
#(
   parameter int SAMPLE_BITS     = 10,
   parameter int RECIP_FRAC_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   aatk_req_if.sink    req_if,
   aatk_rsp_if.source  rsp_if
);

   localparam int PROD_BITS = diff_bits(SAMPLE_BITS) + RECIP_FRAC_BITS - 1;

   logic                        code_valid;
   logic                        code_ready;
   logic [SAMPLE_BITS-1:0]      code;
   channel_type                 code_channel;

   logic                        prod_valid;
   logic                        prod_ready;
   logic signed [PROD_BITS-1:0] product;
   seg_idx_type                 prod_seg;
   channel_type                 prod_channel;

   aatk_average #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_average (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .code_valid   (code_valid),
      .code_ready   (code_ready),
      .code         (code),
      .code_channel (code_channel)
   );

   aatk_segment #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
   ) u_segment (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (code_valid),
      .in_ready    (code_ready),
      .code        (code),
      .in_channel  (code_channel),
      .out_valid   (prod_valid),
      .out_ready   (prod_ready),
      .product     (product),
      .out_seg     (prod_seg),
      .out_channel (prod_channel)
   );

   aatk_kelvin #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
   ) u_kelvin (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (prod_valid),
      .in_ready   (prod_ready),
      .product    (product),
      .in_seg     (prod_seg),
      .in_channel (prod_channel),
      .rsp_if     (rsp_if)
   );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for adc_average_to_kelvin, burst averaging and kelvin conversion
// depends on aatk_pkg, aatk_if and the adc_average_to_kelvin rtl

module tb;
   import aatk_pkg::*;

   localparam int SAMPLE_BITS    = 10;
   localparam int FRAC_BITS      = 20;
   localparam int N_SEG          = 9;
   localparam int CELSIUS_OFFSET = 273;
   localparam int N_DIRECTED     = 24;
   localparam int ITEM_TARGET    = 1250;
   localparam int DRAIN_EVERY    = 300;
   localparam int LONG_STALL     = 60;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 1000;

   // thermistor segments: upper code, celsius at that code, codes per degree in hundredths
   localparam int BREAK_CODE [N_SEG]     = '{289, 342, 398, 455, 512, 566, 619, 667, 712};
   localparam int BASE_CELSIUS [N_SEG]   = '{5, 10, 15, 20, 25, 30, 35, 40, 45};
   localparam int DIV_HUNDREDTHS [N_SEG] = '{982, 1060, 1112, 1136, 1132, 1100, 1044, 973, 890};

   typedef logic [SAMPLE_BITS-1:0] code_type;

   typedef struct packed {
      code_type    sample;
      channel_type channel;
      logic        first;
      logic        last;
      logic        has_kelvin;
      kelvin_type  kelvin;
   } stim_row_type;

   typedef struct {
      kelvin_type  kelvin;
      channel_type channel;
   } reading_type;

   // kelvin typed in only at breakpoints and the code extremes
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{10'd5,    3'd1, 1'b0, 1'b1, 1'b0, 9'd0},
      '{10'd0,    3'd0, 1'b1, 1'b1, 1'b1, 9'd249},
      '{10'd1023, 3'd7, 1'b1, 1'b1, 1'b1, 9'd352},
      '{10'd289,  3'd2, 1'b1, 1'b1, 1'b1, 9'd278},
      '{10'd342,  3'd3, 1'b1, 1'b1, 1'b1, 9'd283},
      '{10'd398,  3'd4, 1'b1, 1'b1, 1'b1, 9'd288},
      '{10'd455,  3'd5, 1'b1, 1'b1, 1'b1, 9'd293},
      '{10'd512,  3'd6, 1'b1, 1'b1, 1'b1, 9'd298},
      '{10'd566,  3'd7, 1'b1, 1'b1, 1'b1, 9'd303},
      '{10'd619,  3'd0, 1'b1, 1'b1, 1'b1, 9'd308},
      '{10'd667,  3'd1, 1'b1, 1'b1, 1'b1, 9'd313},
      '{10'd712,  3'd2, 1'b1, 1'b1, 1'b1, 9'd318},
      '{10'd290,  3'd3, 1'b1, 1'b1, 1'b0, 9'd0},
      '{10'd713,  3'd4, 1'b1, 1'b1, 1'b0, 9'd0},
      '{10'd100,  3'd5, 1'b1, 1'b0, 1'b0, 9'd0},
      '{10'd900,  3'd6, 1'b0, 1'b0, 1'b0, 9'd0},
      '{10'd1023, 3'd7, 1'b0, 1'b1, 1'b0, 9'd0},
      '{10'd1023, 3'd0, 1'b1, 1'b0, 1'b0, 9'd0},
      '{10'd1023, 3'd1, 1'b0, 1'b0, 1'b0, 9'd0},
      '{10'd1023, 3'd2, 1'b0, 1'b1, 1'b1, 9'd352},
      '{10'd0,    3'd3, 1'b1, 1'b0, 1'b0, 9'd0},
      '{10'd0,    3'd4, 1'b0, 1'b1, 1'b1, 9'd249},
      '{10'd682,  3'd5, 1'b1, 1'b0, 1'b0, 9'd0},
      '{10'd341,  3'd6, 1'b0, 1'b1, 1'b0, 9'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   aatk_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_if ();
   aatk_rsp_if rsp_if ();

   adc_average_to_kelvin #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .RECIP_FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always #4 clock = ~clock;

   reading_type pending_readings [$];
   code_type    tracked_average = '0;
   logic [SAMPLE_BITS:0] average_sum;
   reading_type got_reading;
   reading_type want_reading;
   logic        row_has_kelvin = 1'b0;
   kelvin_type  row_kelvin = '0;
   bit          quiet = 1'b0;
   bit          hold_off_request = 1'b0;
   int          mismatches = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          idle_cycles = 0;

   task automatic report(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   function automatic kelvin_type kelvin_of(input code_type code);
      int     seg;
      longint recip;
      longint diff;
      longint acc;
      longint celsius;
      longint k;
      seg = N_SEG - 1;
      for (int i = N_SEG - 2; i >= 0; i--) begin
         if (code <= BREAK_CODE[i]) begin
            seg = i;
         end
      end
      recip = ((longint'(100) << FRAC_BITS) + DIV_HUNDREDTHS[seg] / 2) / DIV_HUNDREDTHS[seg];
      diff = longint'(code) - BREAK_CODE[seg];
      acc = (longint'(BASE_CELSIUS[seg]) << FRAC_BITS) + diff * recip;
      if (acc >= 0) begin
         celsius = acc >> FRAC_BITS;
      end else begin
         celsius = -((-acc) >> FRAC_BITS);
      end
      k = celsius + CELSIUS_OFFSET;
      if (k < 0) begin
         k = 0;
      end
      if (k > 511) begin
         k = 511;
      end
      return kelvin_type'(k);
   endfunction

   function automatic code_type pick_sample();
      int mode;
      mode = $urandom_range(0, 3);
      case (mode)
         0, 1: begin
            return code_type'($urandom_range(0, 1023));
         end
         2: begin
            return code_type'(BREAK_CODE[$urandom_range(0, N_SEG - 1)] + $urandom_range(0, 4) - 2);
         end
         default: begin
            return $urandom_range(0, 1) ? code_type'($urandom_range(0, 15))
                                        : code_type'($urandom_range(1008, 1023));
         end
      endcase
   endfunction

   task automatic send_item(input code_type sample, input channel_type channel, input logic first,
                            input logic last, input logic has_kelvin, input kelvin_type kelvin);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.sample  <= sample;
      req_if.channel <= channel;
      req_if.first   <= first;
      req_if.last    <= last;
      row_has_kelvin <= has_kelvin;
      row_kelvin     <= kelvin;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      items_sent++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
   endtask

   // burst prediction and result checking
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            if (req_if.first) begin
               tracked_average = req_if.sample;
            end else begin
               average_sum = {1'b0, tracked_average} + {1'b0, req_if.sample};
               tracked_average = average_sum[SAMPLE_BITS:1];
            end
            if (req_if.last) begin
               want_reading.kelvin  = row_has_kelvin ? row_kelvin : kelvin_of(tracked_average);
               want_reading.channel = req_if.channel;
               pending_readings.push_back(want_reading);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            got_reading.kelvin  = rsp_if.kelvin;
            got_reading.channel = rsp_if.channel_out;
            if (pending_readings.size() == 0) begin
               report($sformatf("unexpected result kelvin %0d channel %0d",
                                got_reading.kelvin, got_reading.channel));
            end else begin
               want_reading = pending_readings.pop_front();
               if (got_reading.kelvin !== want_reading.kelvin) begin
                  report($sformatf("kelvin %0d, expected %0d", got_reading.kelvin,
                                   want_reading.kelvin));
               end
               if (got_reading.channel !== want_reading.channel) begin
                  report($sformatf("channel_out %0d, expected %0d", got_reading.channel,
                                   want_reading.channel));
               end
            end
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("timeout: %0d results outstanding", pending_readings.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // result side
   initial begin
      int wait_n;
      rsp_if.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end
         wait_n = quiet ? 0 : $urandom_range(0, 5);
         if (wait_n > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   // sample side
   initial begin
      int   burst_len;
      int   next_drain;
      logic first_bit;
      logic last_bit;
      req_if.valid   = 1'b0;
      req_if.sample  = '0;
      req_if.channel = '0;
      req_if.first   = 1'b0;
      req_if.last    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].sample, directed_rows[i].channel, directed_rows[i].first,
                   directed_rows[i].last, directed_rows[i].has_kelvin, directed_rows[i].kelvin);
      end
      drain();

      // single-sample bursts into a stalled result port
      hold_off_request = 1'b1;
      quiet = 1'b1;
      repeat (16) begin
         send_item(pick_sample(), channel_type'($urandom_range(0, 7)), 1'b1, 1'b1, 1'b0, '0);
      end
      quiet = 1'b0;
      drain();

      next_drain = items_sent + DRAIN_EVERY;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 19) == 0) begin
            quiet = !quiet;
         end
         if ($urandom_range(0, 99) < 85) begin
            burst_len = $urandom_range(1, 8);
            for (int k = 0; k < burst_len; k++) begin
               send_item(pick_sample(), channel_type'($urandom_range(0, 7)), k == 0,
                         k == burst_len - 1, 1'b0, '0);
            end
         end else begin
            first_bit = $urandom_range(0, 1);
            last_bit  = $urandom_range(0, 1);
            send_item(pick_sample(), channel_type'($urandom_range(0, 7)), first_bit, last_bit,
                      1'b0, '0);
         end
         if (items_sent >= next_drain) begin
            drain();
            next_drain = items_sent + DRAIN_EVERY;
         end
      end
      quiet = 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d samples giving %0d results: segment breakpoints, code extremes,",
               items_sent, results_seen);
      $display("bursts of 1 to 8, stray first/last flags and a %0d-cycle result stall",
               LONG_STALL);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
